// ===== rtl/core/udiv64_pkg.sv =====
`default_nettype none

package udiv64_pkg;

  // Port width of every operand and result field
  localparam int unsigned DATA_W = 64;

  // Width over which the division is carried out (8 to 64)
  localparam int unsigned OPERAND_WIDTH = 64;

  // Iteration counter: one quotient bit per step
  localparam int unsigned CNT_W = $clog2(OPERAND_WIDTH);

  typedef logic [DATA_W-1:0]        data_t;
  typedef logic [OPERAND_WIDTH-1:0] opnd_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  // Number of the final step, counted down to zero
  localparam cnt_t LAST_STEP_INIT = cnt_t'(OPERAND_WIDTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;     // capture operands, clear partial remainder
    logic step;     // one restoring division step
    logic publish;  // copy the finished result to the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_step;  // the step now pending is the final one
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/udiv64_in_if.sv =====
`default_nettype none

interface udiv64_in_if;
  import udiv64_pkg::*;

  logic  valid;
  logic  ready;
  data_t dividend;
  data_t divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/udiv64_out_if.sv =====
`default_nettype none

interface udiv64_out_if;
  import udiv64_pkg::*;

  logic  valid;
  logic  ready;
  data_t quotient;
  data_t remainder;
  logic  divide_by_zero;

  modport source (output valid, output quotient, output remainder,
                  output divide_by_zero, input ready);
  modport sink   (input valid, input quotient, input remainder,
                  input divide_by_zero, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/unsigned_divider_64.sv =====
// unsigned_divider_64: 64-bit unsigned integer divider.
//
// Input channel in_txn carries dividend and divisor; output channel out_txn
// carries quotient, remainder and divide_by_zero. Both use valid/ready; a
// transaction completes on a rising clk edge with valid and ready high.
// A zero divisor gives an all-ones quotient, the dividend as remainder and
// divide_by_zero set.
//
// The operands are loaded on the accepting edge; 64 restoring steps of one
// quotient bit each then run through a single 66-bit subtractor, and the
// result is moved to the output register. A new transaction is accepted
// only after the previous result has moved to the output register.
//
// The output register is separate from the working registers, so a new
// transaction is accepted while a result waits to be taken. If the receiver
// stalls, the next finished result waits in the datapath until the output
// register drains; in_txn.ready stays low meanwhile.
// Reset (rst_n, synchronous, active low) returns the controller to idle and
// drops out_txn.valid; any operation in progress is discarded.
`default_nettype none

module unsigned_divider_64 (
  input  wire logic     clk,
  input  wire logic     rst_n,
  udiv64_in_if.sink     in_txn,
  udiv64_out_if.source  out_txn
);
  import udiv64_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer
  udiv64_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_txn.valid),
    .in_ready  (in_txn.ready),
    .out_valid (out_txn.valid),
    .out_ready (out_txn.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Shift-subtract datapath
  udiv64_dp u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .sts            (sts),
    .dividend       (in_txn.dividend),
    .divisor        (in_txn.divisor),
    .quotient       (out_txn.quotient),
    .remainder      (out_txn.remainder),
    .divide_by_zero (out_txn.divide_by_zero)
  );

  // Checks
  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (in_txn.valid && in_txn.ready) |-> cmd.load)
    else $error("input transaction without operand load");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_txn.valid && in_txn.ready) |=> !in_txn.ready)
    else $error("ready still high while an operation runs");

  a_publish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |=> out_txn.valid)
    else $error("published result not presented");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load && (cmd.step || cmd.publish)))
    else $error("conflicting datapath commands");

endmodule

`default_nettype wire

// ===== rtl/core/udiv64_dp.sv =====
`default_nettype none

module udiv64_dp (
  input  wire logic               clk,
  input  wire udiv64_pkg::dp_cmd_t cmd,
  output udiv64_pkg::dp_sts_t     sts,
  input  wire udiv64_pkg::data_t  dividend,
  input  wire udiv64_pkg::data_t  divisor,
  output udiv64_pkg::data_t       quotient,
  output udiv64_pkg::data_t       remainder,
  output logic                    divide_by_zero
);
  import udiv64_pkg::*;

  // Working registers
  opnd_t rem_r, rem_nxt;
  opnd_t quo_r, quo_nxt;
  opnd_t den_r;
  logic  dz_r;
  cnt_t  cnt_r, cnt_nxt;

  // Output register, free to hold a result while the next one is worked on
  opnd_t q_out_r;
  opnd_t r_out_r;
  logic  dz_out_r;

  logic [OPERAND_WIDTH:0]   shifted;
  logic [OPERAND_WIDTH+1:0] diff;
  logic                     borrow;

  // Restoring step: shift in next dividend bit, trial-subtract the divisor.
  // A zero divisor yields all-ones quotient and remainder equal to dividend.
  always_comb begin
    shifted = {rem_r, quo_r[OPERAND_WIDTH-1]};
    diff    = {1'b0, shifted} - {2'b00, den_r};
    borrow  = diff[OPERAND_WIDTH+1];
    rem_nxt = borrow ? shifted[OPERAND_WIDTH-1:0] : diff[OPERAND_WIDTH-1:0];
    quo_nxt = {quo_r[OPERAND_WIDTH-2:0], ~borrow};
    cnt_nxt = cnt_r - cnt_t'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r <= '0;
      quo_r <= dividend[OPERAND_WIDTH-1:0];
      den_r <= divisor[OPERAND_WIDTH-1:0];
      dz_r  <= (divisor[OPERAND_WIDTH-1:0] == '0);
      cnt_r <= LAST_STEP_INIT;
    end else if (cmd.step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      q_out_r  <= quo_r;
      r_out_r  <= rem_r;
      dz_out_r <= dz_r;
    end
  end

  assign sts.last_step  = (cnt_r == '0);
  assign quotient       = data_t'(q_out_r);
  assign remainder      = data_t'(r_out_r);
  assign divide_by_zero = dz_out_r;

endmodule

`default_nettype wire

// ===== rtl/core/udiv64_ctrl.sv =====
`default_nettype none

module udiv64_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output udiv64_pkg::dp_cmd_t      cmd,
  input  wire udiv64_pkg::dp_sts_t sts
);
  import udiv64_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_ready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (sts.last_step) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output transaction flag
  always_comb begin
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire
